// ----- rtl/ias_alp_pkg.sv -----
package ias_alp_pkg;

    typedef enum logic [3:0] {
        PH_COUNT_HI = 4'd0,
        PH_COUNT_LO = 4'd1,
        PH_OBJ_HI   = 4'd2,
        PH_OBJ_LO   = 4'd3,
        PH_TYPE     = 4'd4,
        PH_LEN_HI   = 4'd5,
        PH_CHARSET  = 4'd6,
        PH_LEN_LO   = 4'd7,
        PH_PAYLOAD  = 4'd8,
        PH_IDLE     = 4'd9,
        PH_HALT     = 4'd10
    } ias_phase_t;

    localparam logic [3:0] ROLE_COUNT_HI = 4'd0;
    localparam logic [3:0] ROLE_COUNT_LO = 4'd1;
    localparam logic [3:0] ROLE_OBJ_HI   = 4'd2;
    localparam logic [3:0] ROLE_OBJ_LO   = 4'd3;
    localparam logic [3:0] ROLE_TYPE     = 4'd4;
    localparam logic [3:0] ROLE_LEN_HI   = 4'd5;
    localparam logic [3:0] ROLE_CHARSET  = 4'd6;
    localparam logic [3:0] ROLE_LEN_LO   = 4'd7;
    localparam logic [3:0] ROLE_PAYLOAD  = 4'd8;
    localparam logic [3:0] ROLE_IGNORED  = 4'd9;

    localparam logic [1:0] VT_MISSING = 2'd0;
    localparam logic [1:0] VT_INTEGER = 2'd1;
    localparam logic [1:0] VT_OCTETS  = 2'd2;
    localparam logic [1:0] VT_STRING  = 2'd3;

    localparam logic [7:0] TYPE_CODE_MISSING = 8'd0;
    localparam logic [7:0] TYPE_CODE_INTEGER = 8'd1;
    localparam logic [7:0] TYPE_CODE_OCTETS  = 8'd2;
    localparam logic [7:0] TYPE_CODE_STRING  = 8'd3;

    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN_TYPE = 2'd1;
    localparam logic [1:0] ERR_OCTET_LENGTH = 2'd2;

    localparam logic [15:0] INTEGER_LENGTH     = 16'd4;
    localparam logic [15:0] OCTET_LIMIT_RESET  = 16'd1024;
    localparam logic        REG_OCTET_LIMIT    = 1'b0;

    typedef struct packed {
        logic [3:0]  byte_role;
        logic [15:0] element_index;
        logic [1:0]  value_type;
        logic [15:0] object_id;
        logic [7:0]  payload_byte;
        logic [15:0] payload_length;
        logic [7:0]  charset;
        logic [31:0] integer_value;
        logic        element_done;
        logic        list_done;
        logic [1:0]  error_code;
    } ias_result_t;

endpackage

// ----- rtl/ias_alp_if.sv -----
interface ias_byte_if;
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] data_byte;

    modport source (output valid, output frame_start, output data_byte, input ready);
    modport sink   (input valid, input frame_start, input data_byte, output ready);
endinterface

interface ias_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  byte_role;
    logic [15:0] element_index;
    logic [1:0]  value_type;
    logic [15:0] object_id;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic [7:0]  charset;
    logic [31:0] integer_value;
    logic        element_done;
    logic        list_done;
    logic [1:0]  error_code;

    modport source (
        output valid, output byte_role, output element_index, output value_type,
        output object_id, output payload_byte, output payload_length, output charset,
        output integer_value, output element_done, output list_done, output error_code,
        input ready
    );
    modport sink (
        input valid, input byte_role, input element_index, input value_type,
        input object_id, input payload_byte, input payload_length, input charset,
        input integer_value, input element_done, input list_done, input error_code,
        output ready
    );
    modport monitor (
        input valid, input byte_role, input element_index, input value_type,
        input object_id, input payload_byte, input payload_length, input charset,
        input integer_value, input element_done, input list_done, input error_code,
        input ready
    );
endinterface

// ----- rtl/ias_alp_cfg.sv -----
module ias_alp_cfg
    import ias_alp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] octet_length_limit
);

    logic [15:0] limit_reg;
    logic        wr_en;

    // Bit 2 of the byte address is the register index; only index zero exists.
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_OCTET_LIMIT);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= OCTET_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            limit_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_OCTET_LIMIT) ? {16'd0, limit_reg} : 32'd0;
    assign octet_length_limit = limit_reg;

endmodule

// ----- rtl/ias_alp_core.sv -----
module ias_alp_core
    import ias_alp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        frame_start,
    input  logic [7:0]  data_byte,
    input  logic [15:0] octet_length_limit,
    output ias_result_t result
);

    ias_phase_t  phase_reg, phase_eff, phase_next;
    logic [15:0] elements_left_reg, elements_left_eff, elements_left_next;
    logic [15:0] element_counter_reg, element_counter_eff, element_counter_next;
    logic [15:0] bytes_left_reg, bytes_left_eff, bytes_left_next;
    logic [1:0]  type_reg, type_eff, type_next;
    logic [15:0] object_reg, object_eff, object_next;
    logic [15:0] length_reg, length_eff, length_next;
    logic [7:0]  charset_reg, charset_eff, charset_next;
    logic [31:0] integer_reg, integer_eff, integer_next;
    logic [1:0]  error_reg, error_eff, error_next;

    always_comb
    begin
        logic [3:0]  role;
        logic [7:0]  pbyte;
        logic        edone;
        logic        ldone;
        logic        finish;
        logic [15:0] len_full;

        // A frame start throws away whatever the parser was doing.
        phase_eff           = frame_start ? PH_COUNT_HI : phase_reg;
        elements_left_eff   = frame_start ? 16'd0 : elements_left_reg;
        element_counter_eff = frame_start ? 16'd0 : element_counter_reg;
        bytes_left_eff      = frame_start ? 16'd0 : bytes_left_reg;
        type_eff            = frame_start ? VT_MISSING : type_reg;
        object_eff          = frame_start ? 16'd0 : object_reg;
        length_eff          = frame_start ? 16'd0 : length_reg;
        charset_eff         = frame_start ? 8'd0 : charset_reg;
        integer_eff         = frame_start ? 32'd0 : integer_reg;
        error_eff           = frame_start ? ERR_NONE : error_reg;

        phase_next           = phase_eff;
        elements_left_next   = elements_left_eff;
        element_counter_next = element_counter_eff;
        bytes_left_next      = bytes_left_eff;
        type_next            = type_eff;
        object_next          = object_eff;
        length_next          = length_eff;
        charset_next         = charset_eff;
        integer_next         = integer_eff;
        error_next           = error_eff;

        role     = ROLE_IGNORED;
        pbyte    = 8'd0;
        edone    = 1'b0;
        ldone    = 1'b0;
        finish   = 1'b0;
        len_full = {length_eff[15:8], data_byte};

        unique case (phase_eff)
            PH_COUNT_HI:
            begin
                role               = ROLE_COUNT_HI;
                elements_left_next = {data_byte, 8'd0};
                phase_next         = PH_COUNT_LO;
            end
            PH_COUNT_LO:
            begin
                role               = ROLE_COUNT_LO;
                elements_left_next = {elements_left_eff[15:8], data_byte};
                if ({elements_left_eff[15:8], data_byte} == 16'd0)
                begin
                    ldone      = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_OBJ_HI;
                end
            end
            PH_OBJ_HI:
            begin
                role            = ROLE_OBJ_HI;
                type_next       = VT_MISSING;
                length_next     = 16'd0;
                charset_next    = 8'd0;
                integer_next    = 32'd0;
                bytes_left_next = 16'd0;
                object_next     = {data_byte, 8'd0};
                phase_next      = PH_OBJ_LO;
            end
            PH_OBJ_LO:
            begin
                role        = ROLE_OBJ_LO;
                object_next = {object_eff[15:8], data_byte};
                phase_next  = PH_TYPE;
            end
            PH_TYPE:
            begin
                role = ROLE_TYPE;
                unique case (data_byte)
                    TYPE_CODE_MISSING:
                    begin
                        type_next = VT_MISSING;
                        finish    = 1'b1;
                    end
                    TYPE_CODE_INTEGER:
                    begin
                        type_next       = VT_INTEGER;
                        length_next     = INTEGER_LENGTH;
                        bytes_left_next = INTEGER_LENGTH;
                        phase_next      = PH_PAYLOAD;
                    end
                    TYPE_CODE_OCTETS:
                    begin
                        type_next  = VT_OCTETS;
                        phase_next = PH_LEN_HI;
                    end
                    TYPE_CODE_STRING:
                    begin
                        type_next  = VT_STRING;
                        phase_next = PH_CHARSET;
                    end
                    default:
                    begin
                        error_next = ERR_UNKNOWN_TYPE;
                        phase_next = PH_HALT;
                    end
                endcase
            end
            PH_LEN_HI:
            begin
                role        = ROLE_LEN_HI;
                length_next = {data_byte, 8'd0};
                phase_next  = PH_LEN_LO;
            end
            PH_CHARSET:
            begin
                role         = ROLE_CHARSET;
                charset_next = data_byte;
                phase_next   = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                role = ROLE_LEN_LO;
                if (type_eff == VT_OCTETS)
                begin
                    length_next = len_full;
                end
                else
                begin
                    length_next = {8'd0, data_byte};
                end
                if ((type_eff == VT_OCTETS) && (len_full > octet_length_limit))
                begin
                    error_next = ERR_OCTET_LENGTH;
                    phase_next = PH_HALT;
                end
                else
                begin
                    bytes_left_next = length_next;
                    if (length_next == 16'd0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                role  = ROLE_PAYLOAD;
                pbyte = data_byte;
                if (type_eff == VT_INTEGER)
                begin
                    integer_next = {integer_eff[23:0], data_byte};
                end
                if (bytes_left_eff != 16'd0)
                begin
                    bytes_left_next = bytes_left_eff - 16'd1;
                end
                if (bytes_left_next == 16'd0)
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                role = ROLE_IGNORED;
            end
        endcase

        if (finish)
        begin
            edone                = 1'b1;
            element_counter_next = element_counter_eff + 16'd1;
            elements_left_next   = elements_left_next - 16'd1;
            if (elements_left_next == 16'd0)
            begin
                ldone      = 1'b1;
                phase_next = PH_IDLE;
            end
            else
            begin
                phase_next = PH_OBJ_HI;
            end
        end

        // After the list or after an error every field reads zero but the error and the byte role, which reads ignored.
        if ((phase_eff == PH_IDLE) || (phase_eff == PH_HALT))
        begin
            result = '0;
            result.byte_role = ROLE_IGNORED;
        end
        else
        begin
            result.byte_role      = role;
            result.element_index  = element_counter_eff;
            result.value_type     = type_next;
            result.object_id      = object_next;
            result.payload_byte   = pbyte;
            result.payload_length = length_next;
            result.charset        = charset_next;
            result.integer_value  = integer_next;
            result.element_done   = edone;
            result.list_done      = ldone;
            result.error_code     = ERR_NONE;
        end
        result.error_code = error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_COUNT_HI;
            elements_left_reg   <= 16'd0;
            element_counter_reg <= 16'd0;
            bytes_left_reg      <= 16'd0;
            type_reg            <= VT_MISSING;
            object_reg          <= 16'd0;
            length_reg          <= 16'd0;
            charset_reg         <= 8'd0;
            integer_reg         <= 32'd0;
            error_reg           <= ERR_NONE;
        end
        else if (accept)
        begin
            phase_reg           <= phase_next;
            elements_left_reg   <= elements_left_next;
            element_counter_reg <= element_counter_next;
            bytes_left_reg      <= bytes_left_next;
            type_reg            <= type_next;
            object_reg          <= object_next;
            length_reg          <= length_next;
            charset_reg         <= charset_next;
            integer_reg         <= integer_next;
            error_reg           <= error_next;
        end
    end

endmodule

// ----- rtl/ias_alp_outbuf.sv -----
module ias_alp_outbuf
    import ias_alp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  ias_result_t push_data,
    output logic        can_push,
    output logic        out_valid,
    input  logic        out_ready,
    output ias_result_t out_data
);

    ias_result_t main_data_reg;
    ias_result_t skid_data_reg;
    logic        main_valid_reg;
    logic        skid_valid_reg;
    logic        pop;

    assign pop      = main_valid_reg && out_ready;
    // The skid slot catches a word that arrives while the output is stalled.
    assign can_push = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (main_valid_reg && !pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    main_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                main_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                main_data_reg <= push_data;
            end
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

// ----- rtl/ias_attribute_list_parser_top.sv -----
// IAS attribute value list parser. One byte word is taken per clock cycle
// while the output buffer has room, and each byte gives exactly one result word.
// The parse state is updated by a single pass of logic per byte, so the rate
// is one word per cycle for as long as the result side keeps taking words; a
// two-word output buffer lets one further byte in while a result is stalled.
// Raising frame_start on a byte restarts parsing with that byte as the count
// high byte. An unknown value type, or an octet sequence length above the
// octet_length_limit register (byte address 0, reset 1024), sets error_code
// and every following byte is reported as ignored until the next frame start.
// The limit register should be written only while no bytes are in flight.
module ias_attribute_list_parser_top
    import ias_alp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ias_byte_if.sink    byte_in,
    ias_result_if.source result_out
);

    logic [15:0] octet_length_limit;
    logic        accept;
    logic        can_push;
    ias_result_t core_result;
    ias_result_t out_data;

    assign byte_in.ready = can_push;
    assign accept        = byte_in.valid && can_push;

    ias_alp_cfg u_cfg (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .octet_length_limit (octet_length_limit)
    );

    ias_alp_core u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .frame_start        (byte_in.frame_start),
        .data_byte          (byte_in.data_byte),
        .octet_length_limit (octet_length_limit),
        .result             (core_result)
    );

    ias_alp_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .can_push  (can_push),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .out_data  (out_data)
    );

    assign result_out.byte_role      = out_data.byte_role;
    assign result_out.element_index  = out_data.element_index;
    assign result_out.value_type     = out_data.value_type;
    assign result_out.object_id      = out_data.object_id;
    assign result_out.payload_byte   = out_data.payload_byte;
    assign result_out.payload_length = out_data.payload_length;
    assign result_out.charset        = out_data.charset;
    assign result_out.integer_value  = out_data.integer_value;
    assign result_out.element_done   = out_data.element_done;
    assign result_out.list_done      = out_data.list_done;
    assign result_out.error_code     = out_data.error_code;

endmodule

// ----- rtl/ias_alp_checker.sv -----
module ias_alp_checker
    import ias_alp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [3:0]  byte_role,
    input logic [31:0] integer_value,
    input logic        element_done,
    input logic        list_done,
    input logic [1:0]  error_code
);

    // A stalled result word must stay in place until it is taken.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !ready) |=>
        (valid && $stable(byte_role) && $stable(integer_value) && $stable(error_code)))
        else $error("result word changed while stalled");

    // An element can only complete on a type, length low or payload byte.
    a_done_role: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && element_done) |->
        ((byte_role == ROLE_TYPE) || (byte_role == ROLE_LEN_LO)
         || (byte_role == ROLE_PAYLOAD)))
        else $error("element_done on a byte that cannot end an element");

    // Without a completed element, only an empty list count ends the list.
    a_list_role: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && list_done && !element_done) |->
        (byte_role == ROLE_COUNT_LO))
        else $error("list_done without element_done outside the count byte");

    // An error is only raised by a type byte or a length low byte, then stays on ignored bytes.
    a_error_role: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (error_code != ERR_NONE)) |->
        ((byte_role == ROLE_TYPE) || (byte_role == ROLE_LEN_LO)
         || (byte_role == ROLE_IGNORED)))
        else $error("error reported on an unexpected byte role");

endmodule

bind ias_attribute_list_parser_top ias_alp_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (result_out.valid),
    .ready         (result_out.ready),
    .byte_role     (result_out.byte_role),
    .integer_value (result_out.integer_value),
    .element_done  (result_out.element_done),
    .list_done     (result_out.list_done),
    .error_code    (result_out.error_code)
);
